/* src/cnme_pkg.sv */
// shared types, codes and helpers of the consensus node message engine
`timescale 1ns / 1ps
`default_nettype none

package cnme_pkg;

  localparam int unsigned NODE_COUNT = 5;
  localparam logic [13:0] BALLOT_MAX = 14'd9999;
  localparam logic [31:0] BALLOT_LIMIT = 32'd10000;
  localparam int unsigned KNOWN_COUNT = 5;

  // input message codes
  localparam logic [2:0] FN_ELECTION = 3'd0;
  localparam logic [2:0] FN_COORD    = 3'd1;
  localparam logic [2:0] FN_PREPARE  = 3'd2;
  localparam logic [2:0] FN_PROMISE  = 3'd3;
  localparam logic [2:0] FN_ACCEPT   = 3'd4;
  localparam logic [2:0] FN_ACCEPTED = 3'd5;
  localparam logic [2:0] FN_CLIENT   = 3'd6;
  localparam logic [2:0] FN_START    = 3'd7;

  // result message codes
  localparam logic [2:0] KD_ELECTION  = 3'd0;
  localparam logic [2:0] KD_COORD     = 3'd1;
  localparam logic [2:0] KD_PREPARE   = 3'd2;
  localparam logic [2:0] KD_PROMISE   = 3'd3;
  localparam logic [2:0] KD_ACCEPT    = 3'd4;
  localparam logic [2:0] KD_ACCEPTED  = 3'd5;
  localparam logic [2:0] KD_CLIENT_OK = 3'd6;
  localparam logic [2:0] KD_ANNOUNCE  = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_OWN_NODE = 3'd0;
  localparam logic [2:0] CFG_KNOWN_A  = 3'd1;
  localparam logic [2:0] CFG_KNOWN_B  = 3'd2;
  localparam logic [2:0] CFG_KNOWN_C  = 3'd3;
  localparam logic [2:0] CFG_KNOWN_D  = 3'd4;
  localparam logic [2:0] CFG_KNOWN_E  = 3'd5;

  typedef struct packed {
    logic [2:0]                   own_node;
    logic [KNOWN_COUNT-1:0][31:0] known;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  sender;
    logic [15:0] rnd;
    logic [31:0] payload;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  target;
    logic [15:0] rnd;
    logic [31:0] value;
    logic        last;
  } res_t;

  function automatic logic is_known(input logic [31:0] v, input cfg_t c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KNOWN_COUNT; i++) begin
      if (c.known[i] == v) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* src/cnme_cfg.sv */
// configuration registers: own node id and the table of known values
`timescale 1ns / 1ps
`default_nettype none

module cnme_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_wdata_i,
  output cnme_pkg::cfg_t     cfg_o
);
  import cnme_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_node <= 3'd1;
      cfg_q.known[0] <= 32'd42;
      cfg_q.known[1] <= 32'd99;
      cfg_q.known[2] <= 32'd7;
      cfg_q.known[3] <= 32'd1234;
      cfg_q.known[4] <= 32'd56;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_NODE: cfg_q.own_node <= cfg_wdata_i[2:0];
        CFG_KNOWN_A:  cfg_q.known[0] <= cfg_wdata_i;
        CFG_KNOWN_B:  cfg_q.known[1] <= cfg_wdata_i;
        CFG_KNOWN_C:  cfg_q.known[2] <= cfg_wdata_i;
        CFG_KNOWN_D:  cfg_q.known[3] <= cfg_wdata_i;
        CFG_KNOWN_E:  cfg_q.known[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/cnme_core.sv */
// election and agreement state with the per-item decision logic
`timescale 1ns / 1ps
`default_nettype none

module cnme_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire cnme_pkg::item_t item_i,
  input  wire cnme_pkg::cfg_t  cfg_i,
  output cnme_pkg::res_t       res0_o,
  output cnme_pkg::res_t       res1_o,
  output logic [1:0]           n_res_o
);
  import cnme_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ELECT    = 3'd1,
    PH_READY    = 3'd2,
    PH_PROMISE  = 3'd3,
    PH_ACCEPTED = 3'd4
  } phase_e;

  localparam logic [2:0] ELECT_PEERS = 3'(NODE_COUNT - 1);
  localparam logic [3:0] MAJORITY    = 4'(NODE_COUNT / 2);

  phase_e      phase_q, phase_d;
  logic [2:0]  leader_q, leader_d;
  logic [13:0] best_ballot_q, best_ballot_d;
  logic [2:0]  best_node_q, best_node_d;
  logic [2:0]  seen_q, seen_d;
  logic [15:0] round_count_q, round_count_d;
  logic [3:0]  tally_q, tally_d;
  logic [31:0] agreed_q, agreed_d;
  logic [31:0] round_value_q, round_value_d;
  logic [31:0] waiting_value_q, waiting_value_d;
  logic        waiting_flag_q, waiting_flag_d;

  always_comb begin
    logic [13:0] ballot;
    logic [13:0] bb;
    logic [2:0]  bnode;
    logic [2:0]  seen_inc;
    logic [3:0]  tally_inc;
    logic [15:0] next_round;
    res_t        r0;
    res_t        r1;
    logic [1:0]  n;

    phase_d         = phase_q;
    leader_d        = leader_q;
    best_ballot_d   = best_ballot_q;
    best_node_d     = best_node_q;
    seen_d          = seen_q;
    round_count_d   = round_count_q;
    tally_d         = tally_q;
    agreed_d        = agreed_q;
    round_value_d   = round_value_q;
    waiting_value_d = waiting_value_q;
    waiting_flag_d  = waiting_flag_q;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;

    // ballot clamped to 0..9999
    if (item_i.payload[31]) begin
      ballot = '0;
    end else if (item_i.payload >= BALLOT_LIMIT) begin
      ballot = BALLOT_MAX;
    end else begin
      ballot = item_i.payload[13:0];
    end
    bb = best_ballot_q;
    bnode = best_node_q;
    if (ballot > best_ballot_q ||
        (ballot == best_ballot_q && item_i.sender > best_node_q)) begin
      bb = ballot;
      bnode = item_i.sender;
    end
    seen_inc   = seen_q + 3'd1;
    tally_inc  = tally_q + 4'd1;
    next_round = round_count_q + 16'd1;

    if (item_i.func == FN_START) begin
      best_ballot_d  = ballot;
      best_node_d    = cfg_i.own_node;
      seen_d         = '0;
      leader_d       = '0;
      tally_d        = '0;
      waiting_flag_d = 1'b0;
      phase_d        = PH_ELECT;
      r0 = '{kind: KD_ELECTION, target: 3'd0, rnd: 16'd0,
             value: {18'd0, ballot}, last: 1'b0};
      n = 2'd1;
    end else if (phase_q == PH_ELECT) begin
      if (item_i.func == FN_ELECTION) begin
        best_ballot_d = bb;
        best_node_d   = bnode;
        seen_d        = seen_inc;
        if (seen_inc >= ELECT_PEERS) begin
          leader_d = bnode;
          phase_d  = PH_READY;
          r0 = '{kind: KD_COORD, target: 3'd0, rnd: 16'd0,
                 value: {29'd0, bnode}, last: 1'b0};
          n = 2'd1;
          if (bnode == cfg_i.own_node) begin
            r1 = '{kind: KD_ANNOUNCE, target: 3'd0, rnd: 16'd0,
                   value: {29'd0, cfg_i.own_node}, last: 1'b0};
            n = 2'd2;
          end
        end
      end
    end else if (phase_q != PH_IDLE) begin
      if (item_i.func == FN_COORD) begin
        leader_d = item_i.payload[2:0];
      end else if (phase_q == PH_READY) begin
        if (leader_q == cfg_i.own_node) begin
          if (item_i.func == FN_CLIENT && is_known(item_i.payload, cfg_i)) begin
            round_count_d = next_round;
            tally_d       = 4'd1;
            round_value_d = item_i.payload;
            phase_d       = PH_PROMISE;
            r0 = '{kind: KD_PREPARE, target: 3'd0, rnd: next_round,
                   value: 32'd0, last: 1'b0};
            n = 2'd1;
          end
        end else if (item_i.func == FN_PREPARE) begin
          r0 = '{kind: KD_PROMISE, target: item_i.sender, rnd: item_i.rnd,
                 value: agreed_q, last: 1'b0};
          n = 2'd1;
        end else if (item_i.func == FN_ACCEPT && is_known(item_i.payload, cfg_i)) begin
          agreed_d = item_i.payload;
          r0 = '{kind: KD_ACCEPTED, target: item_i.sender, rnd: item_i.rnd,
                 value: item_i.payload, last: 1'b0};
          n = 2'd1;
        end
      end else if (item_i.func == FN_CLIENT) begin
        waiting_value_d = item_i.payload;
        waiting_flag_d  = 1'b1;
      end else if (phase_q == PH_PROMISE) begin
        if (item_i.func == FN_PROMISE && item_i.rnd == round_count_q) begin
          tally_d = tally_inc;
          if (tally_inc > MAJORITY) begin
            agreed_d = round_value_q;
            tally_d  = 4'd1;
            phase_d  = PH_ACCEPTED;
            r0 = '{kind: KD_ACCEPT, target: 3'd0, rnd: round_count_q,
                   value: round_value_q, last: 1'b0};
            n = 2'd1;
          end
        end
      end else if (phase_q == PH_ACCEPTED) begin
        if (item_i.func == FN_ACCEPTED && item_i.rnd == round_count_q) begin
          tally_d = tally_inc;
          if (tally_inc > MAJORITY) begin
            phase_d = PH_READY;
            r0 = '{kind: KD_CLIENT_OK, target: 3'd0, rnd: round_count_q,
                   value: round_value_q, last: 1'b0};
            n = 2'd1;
            if (waiting_flag_q) begin
              waiting_flag_d = 1'b0;
              // queued client value opens the next round right away
              if (is_known(waiting_value_q, cfg_i)) begin
                round_count_d = next_round;
                tally_d       = 4'd1;
                round_value_d = waiting_value_q;
                phase_d       = PH_PROMISE;
                r1 = '{kind: KD_PREPARE, target: 3'd0, rnd: next_round,
                       value: 32'd0, last: 1'b0};
                n = 2'd2;
              end
            end
          end
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
    res0_o  = r0;
    res1_o  = r1;
    n_res_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      leader_q        <= '0;
      best_ballot_q   <= '0;
      best_node_q     <= '0;
      seen_q          <= '0;
      round_count_q   <= '0;
      tally_q         <= '0;
      agreed_q        <= '1;
      round_value_q   <= '0;
      waiting_value_q <= '0;
      waiting_flag_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q         <= phase_d;
      leader_q        <= leader_d;
      best_ballot_q   <= best_ballot_d;
      best_node_q     <= best_node_d;
      seen_q          <= seen_d;
      round_count_q   <= round_count_d;
      tally_q         <= tally_d;
      agreed_q        <= agreed_d;
      round_value_q   <= round_value_d;
      waiting_value_q <= waiting_value_d;
      waiting_flag_q  <= waiting_flag_d;
    end
  end

endmodule

`default_nettype wire

/* src/cnme_outq.sv */
// two-entry result buffer that hands out one result item per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module cnme_outq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire cnme_pkg::res_t res0_i,
  input  wire cnme_pkg::res_t res1_i,
  input  wire logic [1:0]     n_res_i,
  input  wire logic           out_stall_i,
  output logic                room_o,
  output logic                out_valid_o,
  output cnme_pkg::res_t      head_o
);
  import cnme_pkg::*;

  res_t       slot0_q, slot1_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // buffer is free for new results once everything left will be gone
  assign room_o      = (count_q == 2'd0) || (count_q == 2'd1 && pop);
  assign head_o      = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i) begin
      count_q <= n_res_i;
    end else if (pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

`default_nettype wire

/* src/consensus_node_message_engine.sv */
// top level of the consensus node message engine
// order: an accepted item is registered, then decided once the result buffer has room;
// its results are loaded into the buffer and offered from there, the second behind the first
// throughput: one item per cycle while items give at most one result and the output is not
// stalled; an item with two results holds the next until its first result has gone out
// reset: clears the election and round state, sets the agreed value to all ones and loads the default config
`timescale 1ns / 1ps
`default_nettype none

module consensus_node_message_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [2:0]  sender_i,
  input  wire logic [15:0] round_in_i,
  input  wire logic signed [31:0] payload_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       out_kind_o,
  output logic [2:0]       target_o,
  output logic [15:0]      round_out_o,
  output logic signed [31:0] value_out_o,
  output logic             last_o
);
  import cnme_pkg::*;

  cfg_t       cfg;
  item_t      item_q;
  logic       in_valid_q;
  logic       fire;
  logic       room;
  logic       take;
  res_t       res0, res1, head;
  logic [1:0] n_res;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{func: func_i, sender: sender_i, rnd: round_in_i, payload: payload_i};
    end
  end

  cnme_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cnme_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_res_o (n_res)
  );

  cnme_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res0_i      (res0),
    .res1_i      (res1),
    .n_res_i     (n_res),
    .out_stall_i (out_stall_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .head_o      (head)
  );

  assign out_kind_o  = head.kind;
  assign target_o    = head.target;
  assign round_out_o = head.rnd;
  assign value_out_o = head.value;
  assign last_o      = head.last;

endmodule

`default_nettype wire
